// ===== sv/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } eng_state_e;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== sv/sha_queue.sv =====
// Module: short command queue between byte intake and hash engine.
`timescale 1ns / 1ps
module sha_queue import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);
  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push, pop;

  assign in_ready_o  = (cnt_q != (QueuePtrW+1)'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end
endmodule

// ===== sv/sha_engine.sv =====
// Module: SHA-256 block gathering, padding, round engine and digest output.
`timescale 1ns / 1ps
module sha_engine import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic [2:0]  out_index_o,
  output logic        out_last_o
);
  eng_state_e  state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic        final_q;
  logic        pad_done_q;
  logic        blank_q;
  logic [2:0]  idx_q;

  logic        take, byte_in, full;
  logic [31:0] s0, s1, wnew, big0, big1, ch, mj, p, q;

  assign take    = cmd_valid_i && cmd_ready_o;
  assign byte_in = take && cmd_i.has_byte;
  assign full    = byte_in && (fill_q == 6'd63);

  assign s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = s1 + w_q[9] + s0 + w_q[0];
  assign big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign p    = v_q[7] + big1 + ch + round_k(rnd_q) + w_q[0];
  assign q    = big0 + mj;

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_word_o  = h_q[idx_q];
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == 3'd7);

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (full) state_d = ST_ROUND;
        else if (take && cmd_i.last) state_d = ST_PAD;
      end
      ST_ROUND:  if (rnd_q == 6'd63) state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (!final_q) state_d = ST_IDLE;
        else if (pad_done_q) state_d = ST_EMIT;
        else state_d = ST_PAD;
      end
      ST_PAD:    state_d = ST_ROUND;
      ST_EMIT:   if (out_ready_i && idx_q == 3'd7) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      bits_q     <= '0;
      rnd_q      <= '0;
      final_q    <= 1'b0;
      pad_done_q <= 1'b0;
      blank_q    <= 1'b0;
      idx_q      <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (byte_in) begin
            fill_q <= fill_q + 6'd1;
            bits_q <= bits_q + 64'd8;
          end
          if (take) final_q <= cmd_i.last;
          if (take && cmd_i.last) begin
            pad_done_q <= 1'b0;
            if (full) fill_q <= 6'd0;
          end
          rnd_q <= '0;
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          idx_q <= '0;
        end
        ST_PAD: begin
          rnd_q <= '0;
          if (blank_q || fill_q < 6'd56) pad_done_q <= 1'b1;
          blank_q <= !blank_q && (fill_q >= 6'd56);
          fill_q <= 6'd0;
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
              bits_q  <= '0;
              final_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // message schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && byte_in) begin
      w_q[fill_q[5:2]][8*(3-int'(fill_q[1:0])) +: 8] <= cmd_i.data_byte;
    end
    if (state_q == ST_IDLE && take && cmd_i.last) begin
      // place the 0x80 marker and clear beyond
      for (int j = 0; j < 64; j++) begin
        if (6'(j) == (full ? 6'd0 : fill_q + 6'(cmd_i.has_byte)) && !full) begin
          w_q[j/4][8*(3-(j%4)) +: 8] <= 8'h80;
        end else if (6'(j) > fill_q + 6'(cmd_i.has_byte) && !full) begin
          w_q[j/4][8*(3-(j%4)) +: 8] <= 8'h00;
        end else if (6'(j) == fill_q && !cmd_i.has_byte && !full) begin
          w_q[j/4][8*(3-(j%4)) +: 8] <= 8'h80;
        end
      end
    end
    if (state_q == ST_PAD) begin
      if (blank_q || fill_q == 6'd0) begin
        // marker already landed in the previous block when blank
        for (int j = 1; j < 14; j++) w_q[j] <= 32'h0;
        w_q[0]  <= blank_q ? 32'h0 : 32'h80000000;
        w_q[14] <= bits_q[63:32];
        w_q[15] <= bits_q[31:0];
      end else if (fill_q < 6'd56) begin
        w_q[14] <= bits_q[63:32];
        w_q[15] <= bits_q[31:0];
      end
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (state_q == ST_IDLE && full) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (state_q == ST_ROUND) begin
      for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + p;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= p + q;
    end
  end
endmodule

// ===== sv/sha256_message_hasher_core.sv =====
// Top level: SHA-256 hasher of a byte stream with digest word output.
//   channel | dir | fields
//   s_axis  | in  | tdata[7:0]=data_byte, tuser=has_byte, tlast=last
//   m_axis  | out | tdata[31:0]=digest_word, tuser[2:0]=word_index, tlast=last_word
// A byte enters the queue when accepted; the single round unit processes each full
// block in turn. A last item adds one or two padded blocks and eight output transfers.
// Reset restores the initial hash values. Either side may stall; the four-entry queue
// takes bytes while the round unit is busy.
`timescale 1ns / 1ps
module sha256_message_hasher_core import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // digest_word
  output logic [2:0]  m_axis_tuser,  // word_index
  output logic        m_axis_tlast
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{data_byte: s_axis_tdata, has_byte: s_axis_tuser, last: s_axis_tlast};

  sha_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_cmd_o(q_cmd)
  );

  sha_engine u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(m_axis_tdata), .out_index_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );
endmodule
